/* hdl/k_nearest_neighbor_insert_defines.svh */
// Assertion macros used by the neighbor list top level.
`ifndef K_NEAREST_NEIGHBOR_INSERT_DEFINES_SVH
`define K_NEAREST_NEIGHBOR_INSERT_DEFINES_SVH

// Checked on every rising edge of clk while rst_n is high.
`define KNN_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge of clk, reset included.
`define KNN_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/knn_pkg.sv */
// Types, constants and codes of the sorted nearest-neighbor list.
`timescale 1ns / 1ps
`default_nettype none
package knn_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int COORD_W     = 16;
  localparam int ID_W        = 16;
  localparam int RANGE_W     = 34;
  localparam int MAXN_W      = 5;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int ADDR_W      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CFG_IDX_W   = 1;
  localparam int FUNC_W      = 2;

  typedef logic [CNT_W-1:0]          cnt_t;
  typedef logic [ADDR_W-1:0]         addr_t;
  typedef logic [RANGE_W-1:0]        dist_t;
  typedef logic [ID_W-1:0]           id_t;
  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [MAXN_W-1:0]         maxn_t;
  typedef logic [CFG_IDX_W-1:0]      cfg_idx_t;

  typedef struct packed {
    dist_t dist_sq;
    id_t   id;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_BEGIN = 2'd0,
    FUNC_OFFER = 2'd1,
    FUNC_READ  = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  localparam cfg_idx_t CFG_MAX_NEIGHBORS = 1'd0;
  localparam cfg_idx_t CFG_START_RANGE   = 1'd1;

  localparam maxn_t MAXN_RESET  = 5'd10;
  localparam dist_t RANGE_RESET = 34'd14745600;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIST,
    ST_SHIFT,
    ST_PLACE,
    ST_EMIT,
    ST_RD_REQ,
    ST_RD_DATA
  } state_t;

endpackage
`default_nettype wire

/* hdl/knn_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module knn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                      clk,
  input  wire logic                                      we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                          wdata,
  input  wire logic                                      re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule
`default_nettype wire

/* hdl/knn_dist.sv */
// Three-stage squared Euclidean distance unit.
`timescale 1ns / 1ps
`default_nettype none
module knn_dist (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire knn_pkg::coord_t cand_x,
  input  wire knn_pkg::coord_t cand_y,
  input  wire knn_pkg::coord_t cand_z,
  input  wire knn_pkg::coord_t own_x,
  input  wire knn_pkg::coord_t own_y,
  input  wire knn_pkg::coord_t own_z,
  output logic                 done,
  output knn_pkg::dist_t       dist_sq
);

  typedef logic signed [knn_pkg::COORD_W:0] diff_t;
  typedef logic [knn_pkg::COORD_W-1:0]      mag_t;
  typedef logic [2*knn_pkg::COORD_W-1:0]    sq_t;

  diff_t dx_r, dy_r, dz_r;
  sq_t   sx_r, sy_r, sz_r;
  knn_pkg::dist_t sum_r;
  logic  v1_r, v2_r, v3_r;
  mag_t  mx, my, mz;

  function automatic mag_t abs_diff(input diff_t d);
    diff_t n;
    n = -d;
    return d[knn_pkg::COORD_W] ? n[knn_pkg::COORD_W-1:0] : d[knn_pkg::COORD_W-1:0];
  endfunction

  assign mx = abs_diff(dx_r);
  assign my = abs_diff(dy_r);
  assign mz = abs_diff(dz_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= start;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
    dx_r  <= diff_t'(own_x) - diff_t'(cand_x);
    dy_r  <= diff_t'(own_y) - diff_t'(cand_y);
    dz_r  <= diff_t'(own_z) - diff_t'(cand_z);
    sx_r  <= sq_t'(mx) * sq_t'(mx);
    sy_r  <= sq_t'(my) * sq_t'(my);
    sz_r  <= sq_t'(mz) * sq_t'(mz);
    sum_r <= knn_pkg::dist_t'(sx_r) + knn_pkg::dist_t'(sy_r) + knn_pkg::dist_t'(sz_r);
  end

  assign done    = v3_r;
  assign dist_sq = sum_r;

endmodule
`default_nettype wire

/* hdl/k_nearest_neighbor_insert.sv */
// Top level of the sorted nearest-neighbor list: control sequencer and list memory.
// Begin, ignored offer, empty readout and unused code go straight to the emit state.
// Offer: the distance unit runs; a rejection then emits, an insertion scans and shifts the
//   entries it passes, places the candidate and emits; readout fetches each entry, then emits it.
// One item is in work at a time; the next is taken once its last result is queued.
// Synchronous active-low reset empties the list and loads the reset configuration.
`timescale 1ns / 1ps
`default_nettype none
`include "k_nearest_neighbor_insert_defines.svh"
module k_nearest_neighbor_insert (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [knn_pkg::FUNC_W-1:0]      in_func,
  input  wire knn_pkg::id_t                    in_agent_id,
  input  wire knn_pkg::coord_t                 in_pos_x,
  input  wire knn_pkg::coord_t                 in_pos_y,
  input  wire knn_pkg::coord_t                 in_pos_z,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic                                 out_accepted,
  output knn_pkg::dist_t                       out_range_sq,
  output knn_pkg::cnt_t                        out_count,
  output logic                                 out_entry_valid,
  output knn_pkg::dist_t                       out_entry_dist_sq,
  output knn_pkg::id_t                         out_entry_id,
  output logic                                 out_last,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire knn_pkg::cfg_idx_t               cfg_index,
  input  wire logic [knn_pkg::RANGE_W-1:0]     cfg_data
);

  knn_pkg::state_t state_r, state_nxt;
  knn_pkg::coord_t own_x_r, own_y_r, own_z_r, own_x_nxt, own_y_nxt, own_z_nxt;
  knn_pkg::id_t    own_id_r, own_id_nxt, cand_id_r, cand_id_nxt;
  knn_pkg::dist_t  range_r, range_nxt, dist_r, dist_nxt, last_r, last_nxt;
  knn_pkg::cnt_t   count_r, count_nxt, cap_r, cap_nxt;
  knn_pkg::addr_t  pos_r, pos_nxt, rd_k_r, rd_k_nxt;
  logic            acc_r, acc_nxt;
  knn_pkg::maxn_t  maxn_r;
  knn_pkg::dist_t  start_r;

  logic            out_valid_r, out_acc_r, out_ev_r, out_last_r;
  knn_pkg::dist_t  out_range_r, out_edist_r;
  knn_pkg::cnt_t   out_count_r;
  knn_pkg::id_t    out_eid_r;
  logic            out_load, out_acc_nxt, out_ev_nxt, out_last_nxt;
  knn_pkg::dist_t  out_edist_nxt;
  knn_pkg::id_t    out_eid_nxt;
  logic            slot_free;

  logic            ram_we, ram_re;
  knn_pkg::addr_t  ram_waddr, ram_raddr;
  knn_pkg::entry_t ram_wdata, ram_rdata;
  logic [knn_pkg::ENTRY_W-1:0] ram_rbits;

  logic            dist_start, dist_done;
  knn_pkg::dist_t  dist_val;
  knn_pkg::cnt_t   cap_now;

  knn_ram #(
    .WIDTH (knn_pkg::ENTRY_W),
    .DEPTH (knn_pkg::MAX_ENTRIES)
  ) u_list (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rbits)
  );

  assign ram_rdata = knn_pkg::entry_t'(ram_rbits);

  knn_dist u_dist (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (dist_start),
    .cand_x  (in_pos_x),
    .cand_y  (in_pos_y),
    .cand_z  (in_pos_z),
    .own_x   (own_x_r),
    .own_y   (own_y_r),
    .own_z   (own_z_r),
    .done    (dist_done),
    .dist_sq (dist_val)
  );

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == knn_pkg::ST_IDLE);
  assign slot_free = !out_valid_r || out_ready;
  assign cap_now   = (32'(maxn_r) > 32'(knn_pkg::MAX_ENTRIES)) ?
                     knn_pkg::cnt_t'(knn_pkg::MAX_ENTRIES) : knn_pkg::cnt_t'(maxn_r);

  always_comb begin
    knn_pkg::cnt_t newc;
    newc          = count_r;
    state_nxt     = state_r;
    own_x_nxt     = own_x_r;
    own_y_nxt     = own_y_r;
    own_z_nxt     = own_z_r;
    own_id_nxt    = own_id_r;
    cand_id_nxt   = cand_id_r;
    range_nxt     = range_r;
    dist_nxt      = dist_r;
    last_nxt      = last_r;
    count_nxt     = count_r;
    cap_nxt       = cap_r;
    pos_nxt       = pos_r;
    rd_k_nxt      = rd_k_r;
    acc_nxt       = acc_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_waddr     = pos_r;
    ram_raddr     = rd_k_r;
    ram_wdata     = '{dist_sq: dist_r, id: cand_id_r};
    dist_start    = 1'b0;
    out_load      = 1'b0;
    out_acc_nxt   = 1'b0;
    out_ev_nxt    = 1'b0;
    out_edist_nxt = '0;
    out_eid_nxt   = '0;
    out_last_nxt  = 1'b1;
    case (state_r)
      knn_pkg::ST_IDLE: begin
        if (in_valid) begin
          acc_nxt   = 1'b0;
          state_nxt = knn_pkg::ST_EMIT;
          case (knn_pkg::func_t'(in_func))
            knn_pkg::FUNC_BEGIN: begin
              own_x_nxt  = in_pos_x;
              own_y_nxt  = in_pos_y;
              own_z_nxt  = in_pos_z;
              own_id_nxt = in_agent_id;
              count_nxt  = '0;
              range_nxt  = start_r;
            end
            knn_pkg::FUNC_OFFER: begin
              if (cap_now != '0 && in_agent_id != own_id_r) begin
                cap_nxt     = cap_now;
                count_nxt   = (count_r > cap_now) ? cap_now : count_r;
                cand_id_nxt = in_agent_id;
                dist_start  = 1'b1;
                state_nxt   = knn_pkg::ST_DIST;
              end
            end
            knn_pkg::FUNC_READ: begin
              if (count_r != '0) begin
                rd_k_nxt  = '0;
                state_nxt = knn_pkg::ST_RD_REQ;
              end
            end
            default: begin
            end
          endcase
        end
      end
      knn_pkg::ST_DIST: begin
        if (dist_done) begin
          dist_nxt = dist_val;
          if (dist_val < range_r) begin
            newc      = (count_r < cap_r) ? count_r + knn_pkg::cnt_t'(1) : count_r;
            count_nxt = newc;
            pos_nxt   = knn_pkg::addr_t'(newc - knn_pkg::cnt_t'(1));
            last_nxt  = dist_val;
            if (newc == knn_pkg::cnt_t'(1)) begin
              state_nxt = knn_pkg::ST_PLACE;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = knn_pkg::addr_t'(newc - knn_pkg::cnt_t'(2));
              state_nxt = knn_pkg::ST_SHIFT;
            end
          end else begin
            state_nxt = knn_pkg::ST_EMIT;
          end
        end
      end
      knn_pkg::ST_SHIFT: begin
        if (dist_r < ram_rdata.dist_sq) begin
          ram_we    = 1'b1;
          ram_waddr = pos_r;
          ram_wdata = ram_rdata;
          if (knn_pkg::cnt_t'(pos_r) == count_r - knn_pkg::cnt_t'(1)) begin
            last_nxt = ram_rdata.dist_sq;
          end
          pos_nxt = pos_r - knn_pkg::addr_t'(1);
          if (pos_r == knn_pkg::addr_t'(1)) begin
            state_nxt = knn_pkg::ST_PLACE;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = pos_r - knn_pkg::addr_t'(2);
          end
        end else begin
          state_nxt = knn_pkg::ST_PLACE;
        end
      end
      knn_pkg::ST_PLACE: begin
        ram_we    = 1'b1;
        ram_waddr = pos_r;
        if (count_r == cap_r) begin
          range_nxt = last_r;
        end
        acc_nxt   = 1'b1;
        state_nxt = knn_pkg::ST_EMIT;
      end
      knn_pkg::ST_EMIT: begin
        if (slot_free) begin
          out_load    = 1'b1;
          out_acc_nxt = acc_r;
          state_nxt   = knn_pkg::ST_IDLE;
        end
      end
      knn_pkg::ST_RD_REQ: begin
        ram_re    = 1'b1;
        ram_raddr = rd_k_r;
        state_nxt = knn_pkg::ST_RD_DATA;
      end
      knn_pkg::ST_RD_DATA: begin
        if (slot_free) begin
          out_load      = 1'b1;
          out_ev_nxt    = 1'b1;
          out_edist_nxt = ram_rdata.dist_sq;
          out_eid_nxt   = ram_rdata.id;
          out_last_nxt  = (knn_pkg::cnt_t'(rd_k_r) + knn_pkg::cnt_t'(1) == count_r);
          if (out_last_nxt) begin
            state_nxt = knn_pkg::ST_IDLE;
          end else begin
            rd_k_nxt  = rd_k_r + knn_pkg::addr_t'(1);
            state_nxt = knn_pkg::ST_RD_REQ;
          end
        end
      end
      default: begin
        state_nxt = knn_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= knn_pkg::ST_IDLE;
      own_x_r     <= '0;
      own_y_r     <= '0;
      own_z_r     <= '0;
      own_id_r    <= '0;
      range_r     <= knn_pkg::RANGE_RESET;
      count_r     <= '0;
      maxn_r      <= knn_pkg::MAXN_RESET;
      start_r     <= knn_pkg::RANGE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      own_x_r  <= own_x_nxt;
      own_y_r  <= own_y_nxt;
      own_z_r  <= own_z_nxt;
      own_id_r <= own_id_nxt;
      range_r  <= range_nxt;
      count_r  <= count_nxt;
      if (cfg_valid && cfg_index == knn_pkg::CFG_MAX_NEIGHBORS) begin
        maxn_r <= knn_pkg::maxn_t'(cfg_data[knn_pkg::MAXN_W-1:0]);
      end
      if (cfg_valid && cfg_index == knn_pkg::CFG_START_RANGE) begin
        start_r <= cfg_data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    cand_id_r <= cand_id_nxt;
    dist_r    <= dist_nxt;
    last_r    <= last_nxt;
    cap_r     <= cap_nxt;
    pos_r     <= pos_nxt;
    rd_k_r    <= rd_k_nxt;
    acc_r     <= acc_nxt;
    if (out_load) begin
      out_acc_r   <= out_acc_nxt;
      out_range_r <= range_r;
      out_count_r <= count_r;
      out_ev_r    <= out_ev_nxt;
      out_edist_r <= out_edist_nxt;
      out_eid_r   <= out_eid_nxt;
      out_last_r  <= out_last_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_accepted      = out_acc_r;
  assign out_range_sq      = out_range_r;
  assign out_count         = out_count_r;
  assign out_entry_valid   = out_ev_r;
  assign out_entry_dist_sq = out_edist_r;
  assign out_entry_id      = out_eid_r;
  assign out_last          = out_last_r;

  `KNN_ASSERT(a_count_bound, (32'(count_r) <= 32'(knn_pkg::MAX_ENTRIES)), "List count exceeds capacity.")
  `KNN_ASSERT(a_rw_apart, (ram_we && ram_re) |-> (ram_waddr != ram_raddr), "List read and write hit one entry.")
  `KNN_ASSERT(a_range_shrinks, (state_r == knn_pkg::ST_PLACE) |=> (range_r <= $past(range_r)), "Insertion widened the range.")
  `KNN_ASSERT(a_load_free, out_load |-> (!out_valid_r || out_ready), "Result overwrote a pending transaction.")
  `KNN_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> (state_r == knn_pkg::ST_IDLE && !out_valid_r), "Reset did not idle the block.")

endmodule
`default_nettype wire

/* bench/knn_result_checker.sv */
// Checker for the sorted neighbor list: predicts every result and compares it on arrival.
`timescale 1ns / 1ps
module knn_result_checker
  import knn_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  logic [FUNC_W-1:0]      in_func,
  input  id_t                    in_agent_id,
  input  coord_t                 in_pos_x,
  input  coord_t                 in_pos_y,
  input  coord_t                 in_pos_z,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  logic                   out_accepted,
  input  dist_t                  out_range_sq,
  input  cnt_t                   out_count,
  input  logic                   out_entry_valid,
  input  dist_t                  out_entry_dist_sq,
  input  id_t                    out_entry_id,
  input  logic                   out_last,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  cfg_idx_t               cfg_index,
  input  logic [RANGE_W-1:0]     cfg_data,
  output int                     pending_results,
  output int                     mismatch_count
);

  typedef struct {
    logic  accepted;
    dist_t range_sq;
    cnt_t  count;
    logic  entry_valid;
    dist_t entry_dist;
    id_t   entry_id;
    logic  last;
  } knn_result_t;

  knn_result_t awaited_results[$];
  knn_result_t got;
  knn_result_t want;

  maxn_t  neighbor_limit;
  dist_t  start_range;
  coord_t own_x;
  coord_t own_y;
  coord_t own_z;
  id_t    own_id;
  dist_t  search_range;
  int     entry_count;
  dist_t  list_dist[MAX_ENTRIES];
  id_t    list_id[MAX_ENTRIES];

  initial begin
    pending_results = 0;
    mismatch_count = 0;
  end

  task automatic report_mismatch(string what, longint unsigned seen, longint unsigned wanted);
    $display("%0t: mismatch in %s: got %0d, expected %0d", $realtime, what, seen, wanted);
    mismatch_count++;
  endtask

  function automatic void queue_result(logic acc, logic valid, dist_t dist_sq, id_t id,
                                       logic last);
    knn_result_t r;
    r.accepted    = acc;
    r.range_sq    = search_range;
    r.count       = cnt_t'(entry_count);
    r.entry_valid = valid;
    r.entry_dist  = dist_sq;
    r.entry_id    = id;
    r.last        = last;
    awaited_results = {awaited_results, r};
  endfunction

  task automatic predict_item(func_t f, id_t id, coord_t px, coord_t py, coord_t pz);
    int     cap;
    int     slot;
    int     k;
    longint dx;
    longint dy;
    longint dz;
    dist_t  d;
    logic   acc;
    acc = 1'b0;
    case (f)
      FUNC_BEGIN: begin
        own_x = px;
        own_y = py;
        own_z = pz;
        own_id = id;
        entry_count = 0;
        search_range = start_range;
        queue_result(1'b0, 1'b0, '0, '0, 1'b1);
      end
      FUNC_OFFER: begin
        cap = (int'(neighbor_limit) > MAX_ENTRIES) ? MAX_ENTRIES : int'(neighbor_limit);
        if (cap != 0 && id != own_id) begin
          dx = longint'(px) - longint'(own_x);
          dy = longint'(py) - longint'(own_y);
          dz = longint'(pz) - longint'(own_z);
          d = dist_t'(dx * dx + dy * dy + dz * dz);
          // A lowered limit trims the list before the candidate is weighed.
          if (entry_count > cap) entry_count = cap;
          if (d < search_range) begin
            if (entry_count < cap) entry_count++;
            slot = entry_count - 1;
            while (slot != 0 && d < list_dist[slot-1]) begin
              list_dist[slot] = list_dist[slot-1];
              list_id[slot] = list_id[slot-1];
              slot--;
            end
            list_dist[slot] = d;
            list_id[slot] = id;
            if (entry_count == cap) search_range = list_dist[entry_count-1];
            acc = 1'b1;
          end
        end
        queue_result(acc, 1'b0, '0, '0, 1'b1);
      end
      FUNC_READ: begin
        if (entry_count == 0) begin
          queue_result(1'b0, 1'b0, '0, '0, 1'b1);
        end else begin
          for (k = 0; k < entry_count; k++) begin
            queue_result(1'b0, 1'b1, list_dist[k], list_id[k], k == entry_count - 1);
          end
        end
      end
      default: begin
        queue_result(1'b0, 1'b0, '0, '0, 1'b1);
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      neighbor_limit = MAXN_RESET;
      start_range = RANGE_RESET;
      own_x = '0;
      own_y = '0;
      own_z = '0;
      own_id = '0;
      search_range = RANGE_RESET;
      entry_count = 0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        list_dist[i] = '0;
        list_id[i] = '0;
      end
      awaited_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_MAX_NEIGHBORS) begin
          neighbor_limit = cfg_data[MAXN_W-1:0];
        end else begin
          start_range = cfg_data;
        end
      end
      if (out_valid && out_ready) begin
        got.accepted    = out_accepted;
        got.range_sq    = out_range_sq;
        got.count       = out_count;
        got.entry_valid = out_entry_valid;
        got.entry_dist  = out_entry_dist_sq;
        got.entry_id    = out_entry_id;
        got.last        = out_last;
        if (awaited_results.size() == 0) begin
          report_mismatch("unpredicted result, entry_id", got.entry_id, 0);
        end else begin
          want = awaited_results.pop_front();
          if (got.accepted !== want.accepted)
            report_mismatch("accepted", got.accepted, want.accepted);
          if (got.range_sq !== want.range_sq)
            report_mismatch("range_sq", got.range_sq, want.range_sq);
          if (got.count !== want.count)
            report_mismatch("count", got.count, want.count);
          if (got.entry_valid !== want.entry_valid)
            report_mismatch("entry_valid", got.entry_valid, want.entry_valid);
          if (got.entry_dist !== want.entry_dist)
            report_mismatch("entry_dist_sq", got.entry_dist, want.entry_dist);
          if (got.entry_id !== want.entry_id)
            report_mismatch("entry_id", got.entry_id, want.entry_id);
          if (got.last !== want.last)
            report_mismatch("last", got.last, want.last);
        end
      end
      if (in_valid && in_ready) begin
        predict_item(func_t'(in_func), in_agent_id, in_pos_x, in_pos_y, in_pos_z);
      end
    end
    pending_results = awaited_results.size();
  end

endmodule

/* bench/testbench.sv */
// Top of the neighbor list bench: clock, reset, stimulus, flow control and verdict.
`timescale 1ns / 1ps
module testbench;
  import knn_pkg::*;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [FUNC_W-1:0]  in_func;
  id_t                in_agent_id;
  coord_t             in_pos_x;
  coord_t             in_pos_y;
  coord_t             in_pos_z;
  logic               out_valid;
  logic               out_ready;
  logic               out_accepted;
  dist_t              out_range_sq;
  cnt_t               out_count;
  logic               out_entry_valid;
  dist_t              out_entry_dist_sq;
  id_t                out_entry_id;
  logic               out_last;
  logic               cfg_valid;
  logic               cfg_ready;
  cfg_idx_t           cfg_index;
  logic [RANGE_W-1:0] cfg_data;

  int pending_results;
  int mismatch_count;
  int items_sent;
  int idle_now;
  int stall_now;

  k_nearest_neighbor_insert u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_func           (in_func),
    .in_agent_id       (in_agent_id),
    .in_pos_x          (in_pos_x),
    .in_pos_y          (in_pos_y),
    .in_pos_z          (in_pos_z),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_accepted      (out_accepted),
    .out_range_sq      (out_range_sq),
    .out_count         (out_count),
    .out_entry_valid   (out_entry_valid),
    .out_entry_dist_sq (out_entry_dist_sq),
    .out_entry_id      (out_entry_id),
    .out_last          (out_last),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  knn_result_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_func           (in_func),
    .in_agent_id       (in_agent_id),
    .in_pos_x          (in_pos_x),
    .in_pos_y          (in_pos_y),
    .in_pos_z          (in_pos_z),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_accepted      (out_accepted),
    .out_range_sq      (out_range_sq),
    .out_count         (out_count),
    .out_entry_valid   (out_entry_valid),
    .out_entry_dist_sq (out_entry_dist_sq),
    .out_entry_id      (out_entry_id),
    .out_last          (out_last),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .pending_results   (pending_results),
    .mismatch_count    (mismatch_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("status: fail");
    $finish;
  end

  initial out_ready = 1'b0;

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_now);
  end

  task automatic send(func_t f, id_t id, coord_t x, coord_t y, coord_t z);
    while ($urandom_range(99) < idle_now) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_func = f;
    in_agent_id = id;
    in_pos_x = x;
    in_pos_y = y;
    in_pos_z = z;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results != 0) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [RANGE_W-1:0] value);
    drain();
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic coord_t near(coord_t base, int spread);
    int v;
    v = int'(base) + int'($urandom_range(2 * spread)) - spread;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return coord_t'(v);
  endfunction

  task automatic send_noise();
    send(func_t'($urandom_range(3)), id_t'($urandom), coord_t'($urandom),
         coord_t'($urandom), coord_t'($urandom));
  endtask

  task automatic run_query();
    id_t    me;
    id_t    cand;
    coord_t ox;
    coord_t oy;
    coord_t oz;
    coord_t cx;
    coord_t cy;
    coord_t cz;
    int     spread;
    int     offers;
    int     i;
    me = id_t'($urandom);
    if ($urandom_range(1) == 0) begin
      ox = coord_t'($urandom);
      oy = coord_t'($urandom);
      oz = coord_t'($urandom);
    end else begin
      ox = near('0, 8000);
      oy = near('0, 8000);
      oz = near('0, 8000);
    end
    case ($urandom_range(4))
      0: spread = 16;
      1: spread = 512;
      2: spread = 2500;
      3: spread = 4000;
      default: spread = 40000;
    endcase
    send(FUNC_BEGIN, me, ox, oy, oz);
    cx = ox;
    cy = oy;
    cz = oz;
    offers = $urandom_range(24);
    for (i = 0; i < offers; i++) begin
      // Reusing the previous position gives a tie in distance.
      if (i == 0 || $urandom_range(99) >= 15) begin
        cx = near(ox, spread);
        cy = near(oy, spread);
        cz = near(oz, spread);
      end
      cand = ($urandom_range(9) == 0) ? me : id_t'($urandom);
      send(FUNC_OFFER, cand, cx, cy, cz);
      if ($urandom_range(19) == 0) send_noise();
      if ($urandom_range(19) == 0) send(FUNC_READ, id_t'($urandom), cx, cy, cz);
    end
    if ($urandom_range(7) == 0) begin
      write_reg(CFG_MAX_NEIGHBORS, RANGE_W'($urandom_range(31)));
      for (i = 0; i < 3; i++) begin
        send(FUNC_OFFER, id_t'($urandom), near(ox, spread), near(oy, spread),
             near(oz, spread));
      end
    end
    send(FUNC_READ, id_t'($urandom), coord_t'($urandom), coord_t'($urandom),
         coord_t'($urandom));
  endtask

  initial begin
    int idle_base;
    int stall_base;
    int phase;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_func = FUNC_BEGIN;
    in_agent_id = '0;
    in_pos_x = '0;
    in_pos_y = '0;
    in_pos_z = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_MAX_NEIGHBORS;
    cfg_data = '0;
    items_sent = 0;
    idle_now = 0;
    stall_now = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send(FUNC_READ, 16'h0000, 16'sd0, 16'sd0, 16'sd0);
    send(FUNC_NONE, 16'hFFFF, 16'sd32767, 16'sd32767, 16'sd32767);
    write_reg(CFG_START_RANGE, '1);
    write_reg(CFG_MAX_NEIGHBORS, RANGE_W'(16));
    send(FUNC_BEGIN, 16'h1234, -16'sd32768, -16'sd32768, -16'sd32768);
    send(FUNC_OFFER, 16'h1234, -16'sd32768, -16'sd32768, -16'sd32768);
    send(FUNC_OFFER, 16'hFFFF, 16'sd32767, 16'sd32767, 16'sd32767);
    send(FUNC_OFFER, 16'h0000, -16'sd32768, -16'sd32768, -16'sd32767);
    send(FUNC_OFFER, 16'h0001, -16'sd32768, -16'sd32768, -16'sd32767);
    send(FUNC_OFFER, 16'h0002, -16'sd32768, -16'sd32768, -16'sd32768);
    send(FUNC_READ, 16'h0000, 16'sd0, 16'sd0, 16'sd0);
    send(FUNC_NONE, 16'h0000, -16'sd32768, -16'sd32768, -16'sd32768);
    // The limit drops below the list length in the middle of a query.
    write_reg(CFG_MAX_NEIGHBORS, RANGE_W'(2));
    send(FUNC_OFFER, 16'h0003, -16'sd32767, -16'sd32768, -16'sd32768);
    write_reg(CFG_MAX_NEIGHBORS, RANGE_W'(1));
    send(FUNC_OFFER, 16'h0004, 16'sd32767, 16'sd32767, 16'sd32767);
    send(FUNC_READ, 16'h0000, 16'sd0, 16'sd0, 16'sd0);
    write_reg(CFG_MAX_NEIGHBORS, RANGE_W'(0));
    send(FUNC_OFFER, 16'h0005, -16'sd32768, -16'sd32768, -16'sd32768);
    write_reg(CFG_START_RANGE, '0);
    write_reg(CFG_MAX_NEIGHBORS, RANGE_W'(31));
    send(FUNC_BEGIN, 16'h0000, 16'sd0, 16'sd0, 16'sd0);
    send(FUNC_OFFER, 16'h0007, 16'sd0, 16'sd0, 16'sd0);
    send(FUNC_READ, 16'h0000, 16'sd0, 16'sd0, 16'sd0);
    write_reg(CFG_START_RANGE, RANGE_W'(64'd12884508675));
    send(FUNC_BEGIN, 16'hFFFF, 16'sd32767, -16'sd32768, 16'sd32767);
    send(FUNC_OFFER, 16'h0000, -16'sd32768, 16'sd32767, -16'sd32768);
    send(FUNC_OFFER, 16'h0001, -16'sd32767, 16'sd32767, -16'sd32768);
    send(FUNC_READ, 16'h0000, 16'sd0, 16'sd0, 16'sd0);

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          idle_base = 0;
          stall_base = 0;
          write_reg(CFG_MAX_NEIGHBORS, RANGE_W'(MAXN_RESET));
          write_reg(CFG_START_RANGE, RANGE_RESET);
        end
        1: begin
          idle_base = 77;
          stall_base = 0;
          write_reg(CFG_MAX_NEIGHBORS, RANGE_W'(16));
          write_reg(CFG_START_RANGE, RANGE_W'(64'd12884508675));
        end
        2: begin
          idle_base = 0;
          stall_base = 77;
          write_reg(CFG_MAX_NEIGHBORS, RANGE_W'(31));
          write_reg(CFG_START_RANGE, RANGE_W'($urandom_range(30000000)));
        end
        default: begin
          idle_base = 20;
          stall_base = 20;
          write_reg(CFG_MAX_NEIGHBORS, RANGE_W'($urandom_range(8, 1)));
          write_reg(CFG_START_RANGE, RANGE_RESET);
        end
      endcase
      while (items_sent < 22 + 90 * (phase + 1)) begin
        idle_now = ($urandom_range(3) == 0) ? 0 : idle_base;
        stall_now = ($urandom_range(3) == 0) ? 0 : stall_base;
        if ($urandom_range(99) < 85) begin
          run_query();
        end else begin
          repeat ($urandom_range(4, 1)) send_noise();
        end
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hdl
hdl/knn_pkg.sv
hdl/knn_ram.sv
hdl/knn_dist.sv
hdl/k_nearest_neighbor_insert.sv
bench/knn_result_checker.sv
bench/testbench.sv
